// ----- src/tmpc_pkg.sv -----
// Package for the timed moisture pump controller: constants, payload types, codes and states.
package tmpc_pkg;

  localparam int unsigned TICKS_PER_HOUR = 3600;
  localparam int unsigned CHANNELS = 4;
  localparam int unsigned POT_FULL_SCALE = 1023;

  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned SEC_W = $clog2(TICKS_PER_HOUR);
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned HOUR_W = 8;
  localparam int unsigned REM_W = HOUR_W + 1;
  localparam int unsigned REM_CNT_W = $clog2(REM_W + 1);
  localparam int unsigned PROD_W = 20;
  localparam int unsigned MAG_W = 18;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(TICKS_PER_HOUR - 1);
  localparam logic [SAMPLE_W:0] POT_SCALE = (SAMPLE_W + 1)'(POT_FULL_SCALE);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DRY_THRESHOLD  = 3'd0,
    REG_RUN_LIMIT      = 3'd1,
    REG_MIN_SPAN_HOURS = 3'd2,
    REG_MAX_SPAN_HOURS = 3'd3,
    REG_PRESENT_MASK   = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_SPAN,
    ST_HOUR_START,
    ST_HOUR_WAIT,
    ST_SCAN_START,
    ST_SCAN_WAIT,
    ST_APPLY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pot_reading;
    logic [SAMPLE_W-1:0] moisture_a;
    logic [SAMPLE_W-1:0] moisture_b;
    logic [SAMPLE_W-1:0] moisture_c;
    logic [SAMPLE_W-1:0] moisture_d;
  } in_req_t;

  typedef struct packed {
    logic [MAX_CHANNELS-1:0] pump_gates;
    logic                    scanned;
    logic [HOUR_W-1:0]       span_hours;
  } out_req_t;

  typedef struct packed {
    logic                en;
    logic [SAMPLE_W-1:0] threshold;
    logic [HOUR_W-1:0]   run_limit;
  } lane_ctl_t;

endpackage

// ----- src/tmpc_rem.sv -----
// Serial remainder unit: one restoring step per cycle.
module tmpc_rem (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [tmpc_pkg::REM_W-1:0]      dividend,
  input  logic [tmpc_pkg::HOUR_W-1:0]     divisor,
  output logic                            done,
  output logic [tmpc_pkg::HOUR_W-1:0]     remainder
);

  logic [tmpc_pkg::REM_CNT_W-1:0] cnt;
  logic [tmpc_pkg::REM_W-1:0]     shift;
  logic [tmpc_pkg::HOUR_W-1:0]    div_q;
  logic [tmpc_pkg::REM_W-1:0]     trial;
  logic                           fits;

  assign trial = {remainder, shift[tmpc_pkg::REM_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= tmpc_pkg::REM_CNT_W'(tmpc_pkg::REM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == tmpc_pkg::REM_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift     <= dividend;
      div_q     <= divisor;
      remainder <= '0;
    end else if (cnt != '0) begin
      shift     <= {shift[tmpc_pkg::REM_W-2:0], 1'b0};
      // The partial remainder stays below the divisor, so it fits in eight bits.
      remainder <= fits ? tmpc_pkg::HOUR_W'(trial - {1'b0, div_q})
                        : tmpc_pkg::HOUR_W'(trial);
    end
  end

endmodule

// ----- src/tmpc_lane.sv -----
// One channel lane: pump state and run count, updated on a scan of that channel.
module tmpc_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  tmpc_pkg::lane_ctl_t           ctl,
  input  logic [tmpc_pkg::SAMPLE_W-1:0] sample,
  output logic                          pump_on
);

  logic [tmpc_pkg::HOUR_W-1:0] run_count;
  logic [tmpc_pkg::HOUR_W-1:0] count_inc;

  assign count_inc = run_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pump_on   <= 1'b0;
      run_count <= '0;
    end else if (ctl.en) begin
      if (sample > ctl.threshold) begin
        // Dry: run one more scan, and force off once the limit is reached.
        if (count_inc == ctl.run_limit) begin
          run_count <= '0;
          pump_on   <= 1'b0;
        end else begin
          run_count <= count_inc;
          pump_on   <= 1'b1;
        end
      end else if (sample < ctl.threshold) begin
        pump_on <= 1'b0;
      end
    end
  end

endmodule

// ----- src/timed_moisture_pump_control.sv -----
// Top level of the timed moisture pump controller: sequencer, span map, lanes and result merge.
//
//   Channel  Direction  Handshake              Payload
//   in       into       in_valid / in_stall    in_data   (pot reading, four moisture samples)
//   out      out of     out_valid / out_stall  out_data  (pump gates, scanned flag, span)
//   cfg      into       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each tick request uses the serial remainder unit for the scan interval test, and once
// more before it for the hour counter step when the seconds counter wraps into a new hour
// and max span is nonzero.
// Reset is synchronous and active high and restores the registers, counters and pump states.
// A stalled result stays in the output register; the next tick request is still taken
// and waits only at its final step until the register is free.
module timed_moisture_pump_control (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tmpc_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tmpc_pkg::out_req_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tmpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tmpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [tmpc_pkg::SAMPLE_W-1:0]     dry_threshold;
  logic [tmpc_pkg::HOUR_W-1:0]       run_limit;
  logic [tmpc_pkg::HOUR_W-1:0]       min_span_hours;
  logic [tmpc_pkg::HOUR_W-1:0]       max_span_hours;
  logic [tmpc_pkg::MAX_CHANNELS-1:0] present_mask;

  // Sequencer and datapath state.
  tmpc_pkg::state_t                  state;
  tmpc_pkg::state_t                  state_next;
  tmpc_pkg::in_req_t                 req;
  logic [tmpc_pkg::SEC_W-1:0]        second_count;
  logic [tmpc_pkg::HOUR_W-1:0]       hour_count;
  logic                              wrap;
  logic signed [tmpc_pkg::PROD_W-1:0] prod;
  logic [tmpc_pkg::MAG_W-1:0]        mag;
  logic                              neg;
  logic [tmpc_pkg::HOUR_W-1:0]       span;
  logic                              scan;

  // Combinational helpers.
  logic                              accept;
  logic                              rem_start;
  logic [tmpc_pkg::REM_W-1:0]        rem_dividend;
  logic [tmpc_pkg::HOUR_W-1:0]       rem_divisor;
  logic                              rem_done;
  logic [tmpc_pkg::HOUR_W-1:0]       rem_value;
  logic                              lane_fire;
  logic                              out_load;
  logic signed [tmpc_pkg::SAMPLE_W:0] pot_s;
  logic signed [tmpc_pkg::HOUR_W:0]  span_diff;
  logic signed [tmpc_pkg::PROD_W-1:0] prod_next;
  logic [tmpc_pkg::HOUR_W-1:0]       q_coarse;
  logic [tmpc_pkg::SAMPLE_W:0]       q_resid;
  logic [tmpc_pkg::HOUR_W-1:0]       quot;
  logic [tmpc_pkg::HOUR_W-1:0]       eff_span;
  logic [tmpc_pkg::MAX_CHANNELS-1:0] gates;
  logic [tmpc_pkg::SAMPLE_W-1:0]     samples [tmpc_pkg::MAX_CHANNELS];

  assign cfg_ready = 1'b1;
  assign in_stall  = state != tmpc_pkg::ST_IDLE;
  assign accept    = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dry_threshold  <= tmpc_pkg::SAMPLE_W'(512);
      run_limit      <= tmpc_pkg::HOUR_W'(5);
      min_span_hours <= tmpc_pkg::HOUR_W'(1);
      max_span_hours <= tmpc_pkg::HOUR_W'(24);
      present_mask   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tmpc_pkg::REG_DRY_THRESHOLD:  dry_threshold  <= cfg_data;
        tmpc_pkg::REG_RUN_LIMIT:      run_limit      <= cfg_data[tmpc_pkg::HOUR_W-1:0];
        tmpc_pkg::REG_MIN_SPAN_HOURS: min_span_hours <= cfg_data[tmpc_pkg::HOUR_W-1:0];
        tmpc_pkg::REG_MAX_SPAN_HOURS: max_span_hours <= cfg_data[tmpc_pkg::HOUR_W-1:0];
        tmpc_pkg::REG_PRESENT_MASK:
          present_mask <= cfg_data[tmpc_pkg::MAX_CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  // Span map: pot * (max - min) is formed at acceptance and registered. Its magnitude is
  // divided by 1023 as (m >> 10) plus a single correction, since m mod 1024 plus the
  // coarse quotient stays below twice 1023. The sign is applied afterwards, so the
  // quotient truncates toward zero.
  assign pot_s     = $signed({1'b0, in_data.pot_reading});
  assign span_diff = $signed({1'b0, max_span_hours}) - $signed({1'b0, min_span_hours});
  assign prod_next = pot_s * span_diff;

  assign q_coarse = mag[tmpc_pkg::MAG_W-1:tmpc_pkg::SAMPLE_W];
  assign q_resid  = {1'b0, mag[tmpc_pkg::SAMPLE_W-1:0]} + (tmpc_pkg::SAMPLE_W + 1)'(q_coarse);
  assign quot     = (q_resid >= tmpc_pkg::POT_SCALE) ? q_coarse + 1'b1 : q_coarse;

  // A span of zero scans on every tick, as a span of one would.
  assign eff_span = (span == '0) ? tmpc_pkg::HOUR_W'(1) : span;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    rem_start    = 1'b0;
    rem_dividend = '0;
    rem_divisor  = max_span_hours;
    lane_fire    = 1'b0;
    out_load     = 1'b0;
    case (state)
      tmpc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = tmpc_pkg::ST_MAG;
        end
      end
      tmpc_pkg::ST_MAG: begin
        state_next = tmpc_pkg::ST_SPAN;
      end
      tmpc_pkg::ST_SPAN: begin
        state_next = tmpc_pkg::ST_HOUR_START;
      end
      tmpc_pkg::ST_HOUR_START: begin
        // The hour counter steps modulo max span; with max span zero it just clears.
        if (wrap && max_span_hours != '0) begin
          rem_start    = 1'b1;
          rem_dividend = {1'b0, hour_count} + 1'b1;
          rem_divisor  = max_span_hours;
          state_next   = tmpc_pkg::ST_HOUR_WAIT;
        end else begin
          state_next = tmpc_pkg::ST_SCAN_START;
        end
      end
      tmpc_pkg::ST_HOUR_WAIT: begin
        if (rem_done) begin
          state_next = tmpc_pkg::ST_SCAN_START;
        end
      end
      tmpc_pkg::ST_SCAN_START: begin
        rem_start    = 1'b1;
        rem_dividend = {1'b0, hour_count};
        rem_divisor  = eff_span;
        state_next   = tmpc_pkg::ST_SCAN_WAIT;
      end
      tmpc_pkg::ST_SCAN_WAIT: begin
        if (rem_done) begin
          state_next = tmpc_pkg::ST_APPLY;
        end
      end
      tmpc_pkg::ST_APPLY: begin
        lane_fire  = scan;
        state_next = tmpc_pkg::ST_OUT;
      end
      tmpc_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = tmpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tmpc_pkg::ST_IDLE;
      end
    endcase
  end

  // Second and hour counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      second_count <= '0;
      hour_count   <= '0;
    end else begin
      if (accept) begin
        second_count <= (second_count == tmpc_pkg::SEC_LAST) ? '0 : second_count + 1'b1;
      end
      if (state == tmpc_pkg::ST_HOUR_START && wrap && max_span_hours == '0) begin
        hour_count <= '0;
      end else if (state == tmpc_pkg::ST_HOUR_WAIT && rem_done) begin
        hour_count <= rem_value;
      end
    end
  end

  // Request payload, span datapath and the scan decision.
  always_ff @(posedge clk) begin
    if (accept) begin
      req  <= in_data;
      wrap <= second_count == tmpc_pkg::SEC_LAST;
      prod <= prod_next;
    end
    if (state == tmpc_pkg::ST_MAG) begin
      neg <= prod[tmpc_pkg::PROD_W-1];
      mag <= prod[tmpc_pkg::PROD_W-1] ? tmpc_pkg::MAG_W'(-prod) : tmpc_pkg::MAG_W'(prod);
    end
    if (state == tmpc_pkg::ST_SPAN) begin
      span <= neg ? min_span_hours - quot : min_span_hours + quot;
    end
    if (state == tmpc_pkg::ST_SCAN_WAIT && rem_done) begin
      scan <= rem_value == '0;
    end
  end

  tmpc_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (rem_divisor),
    .done      (rem_done),
    .remainder (rem_value)
  );

  // Channel lanes; channels beyond the configured count report their pump as off.
  assign samples[0] = req.moisture_a;
  assign samples[1] = req.moisture_b;
  assign samples[2] = req.moisture_c;
  assign samples[3] = req.moisture_d;

  for (genvar ch = 0; ch < tmpc_pkg::MAX_CHANNELS; ch++) begin : g_lane
    if (ch < tmpc_pkg::CHANNELS) begin : g_on
      tmpc_pkg::lane_ctl_t ctl;

      assign ctl.en        = lane_fire && present_mask[ch];
      assign ctl.threshold = dry_threshold;
      assign ctl.run_limit = run_limit;

      tmpc_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .sample  (samples[ch]),
        .pump_on (gates[ch])
      );
    end else begin : g_off
      assign gates[ch] = 1'b0;
    end
  end

  // Result register, which merges the lane states with the scan flag and span.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.pump_gates <= gates;
      out_data.scanned    <= scan;
      out_data.span_hours <= span;
    end
  end

`ifndef SYNTHESIS
  // The lanes update only at the apply step of a tick that scans.
  assert property (@(posedge clk) disable iff (rst)
    lane_fire |-> (state == tmpc_pkg::ST_APPLY && scan))
    else $error("lane update outside the apply step of a scanning tick");

  // After a stepped hour wrap, the hour counter is below max span.
  assert property (@(posedge clk) disable iff (rst)
    (state == tmpc_pkg::ST_HOUR_WAIT && rem_done)
      |=> (hour_count < max_span_hours))
    else $error("hour counter not reduced below max span");

  // A result appears only from the final step of a tick.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == tmpc_pkg::ST_OUT))
    else $error("result raised outside the final step");

  // At the scan interval test, the remainder is always below the effective span.
  assert property (@(posedge clk) disable iff (rst)
    (state == tmpc_pkg::ST_SCAN_WAIT && rem_done) |-> (rem_value < eff_span))
    else $error("scan remainder not below the span");
`endif

endmodule

// ----- test/tmpc_checker.sv -----
// Checker for the timed moisture pump controller: predicts each tick result and compares it.
`timescale 1ns / 1ps

module tmpc_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  tmpc_pkg::in_req_t                in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  tmpc_pkg::out_req_t               out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tmpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tmpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               results_checked,
  output int                               scan_results
);

  localparam int RUN_W = 8;
  localparam int REPORT_LIMIT = 40;

  // Register values after reset.
  localparam logic [tmpc_pkg::SAMPLE_W-1:0]     DEF_THRESHOLD = 10'd512;
  localparam logic [RUN_W-1:0]                  DEF_RUN_LIMIT = 8'd5;
  localparam logic [tmpc_pkg::HOUR_W-1:0]       DEF_MIN_SPAN  = 8'd1;
  localparam logic [tmpc_pkg::HOUR_W-1:0]       DEF_MAX_SPAN  = 8'd24;
  localparam logic [tmpc_pkg::MAX_CHANNELS-1:0] DEF_PRESENT   = 4'hF;

  logic [tmpc_pkg::SAMPLE_W-1:0]     dry_threshold;
  logic [RUN_W-1:0]                  run_limit;
  logic [tmpc_pkg::HOUR_W-1:0]       min_span;
  logic [tmpc_pkg::HOUR_W-1:0]       max_span;
  logic [tmpc_pkg::MAX_CHANNELS-1:0] present_mask;

  int unsigned                       second_count;
  logic [tmpc_pkg::HOUR_W-1:0]       hour_count;
  logic [tmpc_pkg::MAX_CHANNELS-1:0] pump_on;
  logic [RUN_W-1:0]                  run_count [tmpc_pkg::MAX_CHANNELS];

  tmpc_pkg::out_req_t tick_outcomes_due [$];

  // Advances the counters by one second and works out the pump gates for this tick.
  function automatic tmpc_pkg::out_req_t predict_tick_outcome(tmpc_pkg::in_req_t req);
    tmpc_pkg::out_req_t            outcome;
    logic [tmpc_pkg::SAMPLE_W-1:0] sample [tmpc_pkg::MAX_CHANNELS];
    int                            mapped;
    logic [tmpc_pkg::HOUR_W-1:0]   span;
    int unsigned                   interval;
    logic                          scan;
    sample[0] = req.moisture_a;
    sample[1] = req.moisture_b;
    sample[2] = req.moisture_c;
    sample[3] = req.moisture_d;
    second_count = (second_count + 1) % tmpc_pkg::TICKS_PER_HOUR;
    if (second_count == 0) begin
      if (max_span == '0) hour_count = '0;
      else hour_count = tmpc_pkg::HOUR_W'((int'(hour_count) + 1) % int'(max_span));
    end
    // Signed arithmetic so that a minimum above the maximum truncates toward zero.
    mapped = int'(req.pot_reading) * (int'(max_span) - int'(min_span))
             / int'(tmpc_pkg::POT_FULL_SCALE) + int'(min_span);
    span = mapped[tmpc_pkg::HOUR_W-1:0];
    interval = (span == '0) ? 1 : span;
    scan = ((hour_count % interval) == 0);
    for (int ch = 0; ch < tmpc_pkg::MAX_CHANNELS; ch++) begin
      if (ch < tmpc_pkg::CHANNELS && scan && present_mask[ch]) begin
        if (sample[ch] > dry_threshold) begin
          pump_on[ch] = 1'b1;
          run_count[ch] = run_count[ch] + 1'b1;
          if (run_count[ch] == run_limit) begin
            run_count[ch] = '0;
            pump_on[ch] = 1'b0;
          end
        end else if (sample[ch] < dry_threshold) begin
          pump_on[ch] = 1'b0;
        end
      end
      outcome.pump_gates[ch] = (ch < tmpc_pkg::CHANNELS) ? pump_on[ch] : 1'b0;
    end
    outcome.scanned = scan;
    outcome.span_hours = span;
    return outcome;
  endfunction

  function automatic void check_field(string field, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      if (fail_count < REPORT_LIMIT)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    tmpc_pkg::out_req_t due;
    if (rst) begin
      dry_threshold = DEF_THRESHOLD;
      run_limit = DEF_RUN_LIMIT;
      min_span = DEF_MIN_SPAN;
      max_span = DEF_MAX_SPAN;
      present_mask = DEF_PRESENT;
      second_count = 0;
      hour_count = '0;
      pump_on = '0;
      foreach (run_count[ch]) run_count[ch] = '0;
      tick_outcomes_due.delete();
      fail_count = 0;
      results_checked = 0;
      scan_results = 0;
    end else begin
      // Results are taken before new requests so a stray result is never matched
      // against a request accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (tick_outcomes_due.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t ns: result with nothing expected, actual %p", $time, out_data);
          fail_count++;
        end else begin
          due = tick_outcomes_due.pop_front();
          check_field("pump_gates", due.pump_gates, out_data.pump_gates);
          check_field("scanned", due.scanned, out_data.scanned);
          check_field("span_hours", due.span_hours, out_data.span_hours);
          results_checked++;
          if (due.scanned) scan_results++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tmpc_pkg::REG_DRY_THRESHOLD:  dry_threshold = cfg_data[tmpc_pkg::SAMPLE_W-1:0];
          tmpc_pkg::REG_RUN_LIMIT:      run_limit = cfg_data[RUN_W-1:0];
          tmpc_pkg::REG_MIN_SPAN_HOURS: min_span = cfg_data[tmpc_pkg::HOUR_W-1:0];
          tmpc_pkg::REG_MAX_SPAN_HOURS: max_span = cfg_data[tmpc_pkg::HOUR_W-1:0];
          tmpc_pkg::REG_PRESENT_MASK:   present_mask = cfg_data[tmpc_pkg::MAX_CHANNELS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        tick_outcomes_due.push_back(predict_tick_outcome(in_data));
    end
    pending <= tick_outcomes_due.size();
  end

endmodule

// ----- test/tb_timed_moisture_pump_control.sv -----
// Testbench top for the timed moisture pump controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_timed_moisture_pump_control;

  // No request may take longer than this many cycles to move on any channel.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to let pass once every result is in.
  localparam int SETTLE_CYCLES = 30;
  localparam int unsigned SAMPLE_MAX = (1 << tmpc_pkg::SAMPLE_W) - 1;
  localparam int CFG_INDEX_TOP = (1 << tmpc_pkg::CFG_INDEX_W) - 1;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  tmpc_pkg::in_req_t                in_data = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  tmpc_pkg::out_req_t               out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [tmpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tmpc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int pending_results;
  int results_checked;
  int scan_results;

  // Idling controls. The stall percentage is read by another process at the clock
  // edge, so it only ever changes through a nonblocking assignment.
  int gap_pct = 9;
  int stall_pct = 58;

  int ticks_sent = 0;
  int writes_done = 0;
  int quiet_cycles = 0;

  // Threshold last written; it only steers the samples toward the interesting side.
  logic [tmpc_pkg::SAMPLE_W-1:0] cur_threshold = 10'd512;

  timed_moisture_pump_control dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tmpc_checker tick_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending_results),
    .results_checked (results_checked),
    .scan_results    (scan_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The result side stalls at random, one fresh decision per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // The watchdog ends the run when no request has moved on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no request moved for %0d cycles", $time, quiet_cycles);
      $display("tb_timed_moisture_pump_control failed");
      $finish;
    end
  end

  // Offers one tick request and returns at the edge where it is accepted. Valid stays
  // high into the next request unless a gap is drawn, so it is never dropped and
  // raised within one step.
  task automatic send_fields(logic [tmpc_pkg::SAMPLE_W-1:0] pot,
                             logic [tmpc_pkg::SAMPLE_W-1:0] a,
                             logic [tmpc_pkg::SAMPLE_W-1:0] b,
                             logic [tmpc_pkg::SAMPLE_W-1:0] c,
                             logic [tmpc_pkg::SAMPLE_W-1:0] d);
    tmpc_pkg::in_req_t req;
    req.pot_reading = pot;
    req.moisture_a = a;
    req.moisture_b = b;
    req.moisture_c = c;
    req.moisture_d = d;
    // Gap lengths are drawn at random so that they land on every step of the block's work.
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  // Small readings land on the shortest spans; a few full readings reach the longest.
  function automatic logic [tmpc_pkg::SAMPLE_W-1:0] pick_pot(int low_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < low_pct) return tmpc_pkg::SAMPLE_W'($urandom_range(7));
    if (roll < low_pct + 4) return '1;
    return tmpc_pkg::SAMPLE_W'($urandom_range(SAMPLE_MAX));
  endfunction

  // Samples cluster around the threshold: dry with the given chance, otherwise equal,
  // wet, or anywhere at all.
  function automatic logic [tmpc_pkg::SAMPLE_W-1:0] pick_sample(int dry_pct);
    int unsigned thr;
    int unsigned roll;
    thr = cur_threshold;
    roll = $urandom_range(99);
    if (roll < dry_pct) begin
      if (thr == SAMPLE_MAX) return tmpc_pkg::SAMPLE_W'(thr);
      if ($urandom_range(3) == 0) return tmpc_pkg::SAMPLE_W'(thr + 1);
      return tmpc_pkg::SAMPLE_W'($urandom_range(SAMPLE_MAX, thr + 1));
    end
    roll = $urandom_range(9);
    if (roll < 2) return tmpc_pkg::SAMPLE_W'(thr);
    if (roll < 3) return tmpc_pkg::SAMPLE_W'($urandom_range(SAMPLE_MAX));
    if (thr == 0) return '0;
    if ($urandom_range(3) == 0) return tmpc_pkg::SAMPLE_W'(thr - 1);
    return tmpc_pkg::SAMPLE_W'($urandom_range(thr - 1, 0));
  endfunction

  task automatic run_ticks(int count, int dry_pct, int low_pct);
    repeat (count)
      send_fields(pick_pot(low_pct), pick_sample(dry_pct), pick_sample(dry_pct),
                  pick_sample(dry_pct), pick_sample(dry_pct));
  endtask

  // Waits until every expected result has come back and the block has gone quiet.
  // The first edge is always taken, so a request accepted just now is counted.
  task automatic wait_for_drain();
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tmpc_pkg::CFG_INDEX_W-1:0] idx,
                           logic [tmpc_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    writes_done++;
  endtask

  // Withdraws the tick valid and writes all five registers once the block is idle.
  // Data wider than a register is passed on as it stands, so the upper data bits get
  // exercised too. The write valid stays high across the batch and drops once at the end.
  task automatic apply_setting(logic [tmpc_pkg::CFG_DATA_W-1:0] thr,
                               logic [tmpc_pkg::CFG_DATA_W-1:0] limit,
                               logic [tmpc_pkg::CFG_DATA_W-1:0] span_lo,
                               logic [tmpc_pkg::CFG_DATA_W-1:0] span_hi,
                               logic [tmpc_pkg::CFG_DATA_W-1:0] mask,
                               bit poke_unused = 1'b0);
    in_valid <= 1'b0;
    wait_for_drain();
    write_reg(tmpc_pkg::REG_DRY_THRESHOLD, thr);
    write_reg(tmpc_pkg::REG_RUN_LIMIT, limit);
    write_reg(tmpc_pkg::REG_MIN_SPAN_HOURS, span_lo);
    write_reg(tmpc_pkg::REG_MAX_SPAN_HOURS, span_hi);
    write_reg(tmpc_pkg::REG_PRESENT_MASK, mask);
    // Indexes past the last register must leave every setting alone.
    if (poke_unused)
      for (int idx = int'(tmpc_pkg::REG_PRESENT_MASK) + 1; idx <= CFG_INDEX_TOP; idx++)
        write_reg(tmpc_pkg::CFG_INDEX_W'(idx),
                  tmpc_pkg::CFG_DATA_W'($urandom_range(SAMPLE_MAX)));
    cfg_valid <= 1'b0;
    cur_threshold = thr;
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender draws a gap before 9 requests of a hundred; the receiver stalls with a chance of 58 percent.
    // Directed ticks at the reset settings: threshold 512, limit 5, span 1 to 24, all
    // channels present. The hour counter stays at zero over this run, so every tick scans.
    send_fields(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);           // all wet, shortest span
    send_fields(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023); // all dry, longest span
    send_fields(10'd512, 10'd512, 10'd512, 10'd512, 10'd512); // equal to threshold: no change
    send_fields(10'd511, 10'd511, 10'd511, 10'd511, 10'd511); // just wet: pumps stop, counts kept
    send_fields(10'h2AA, 10'd513, 10'd513, 10'd513, 10'd513); // just dry
    send_fields(10'h155, 10'd513, 10'd1023, 10'd600, 10'd700);
    send_fields(10'd1, 10'd600, 10'd600, 10'd600, 10'd600);
    send_fields(10'd1022, 10'd600, 10'd600, 10'd600, 10'd600); // fifth run: forced off
    send_fields(10'd44, 10'd1023, 10'd0, 10'd512, 10'd1023);   // each channel its own way
    send_fields(10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023);
    send_fields(10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0);

    // Highest threshold, limit and spans with every channel absent: nothing can be
    // dry, yet scanned still reports the interval. The data words carry upper bits.
    apply_setting(10'h3FF, 10'h3FF, 10'h2FF, 10'h1FF, 10'h3F0, 1'b1);
    run_ticks(30, 50, 10);
    // Zero threshold, limit of one, both spans zero: the span reads zero and every
    // tick scans; channels 1 and 3 are absent and keep their state.
    apply_setting(10'd0, 10'd1, 10'd0, 10'd0, 10'b0101);
    run_ticks(30, 60, 10);
    // Minimum above maximum, so the span falls as the pot reading rises.
    apply_setting(10'd300, 10'd3, 10'd200, 10'd3, 10'b1011);
    run_ticks(30, 65, 10);
    // A limit of zero with every sample dry: each run count wraps through 256 scans
    // back to the limit, which clears it and forces the pump off.
    apply_setting(10'd512, 10'd0, 10'd1, 10'd3, 10'hF);
    run_ticks(260, 100, 10);

    // Sender draws a gap before 58 requests of a hundred; the receiver stalls with a chance of 9 percent.
    gap_pct = 58;
    stall_pct <= 9;
    apply_setting(10'd700, 10'd2, 10'd1, 10'd3, 10'hF);
    run_ticks(20, 60, 40);
    // A zero minimum maps low readings to a zero span, which scans as a span of one.
    apply_setting(10'd100, 10'd4, 10'd0, 10'd3, 10'b1110);
    run_ticks(20, 70, 40);
    apply_setting(CFG_DATA_W_rand(), 10'd7, 10'd1, 10'd3, 10'hF);
    run_ticks(10, 70, 20);
    // Equal minimum and maximum give the same span for every reading.
    apply_setting(10'd450, 10'd6, 10'd2, 10'd2, 10'hF);
    run_ticks(30, 70, 20);

    // No idling on either side.
    gap_pct = 0;
    stall_pct <= 0;
    apply_setting(CFG_DATA_W_rand(), 10'd10, 10'd1, 10'd255, 10'hF);
    run_ticks(20, 70, 40);
    // A zero maximum below the minimum gives a falling map that reaches zero at the full reading.
    apply_setting(10'd600, 10'd9, 10'd3, 10'd0, 10'hF);
    run_ticks(10, 70, 30);
    apply_setting(10'd512, 10'd5, 10'd1, 10'd24, 10'hF);
    run_ticks(30, 60, 10);

    in_valid <= 1'b0;
    wait_for_drain();

    $display("Covered %0d tick requests and %0d register writes under three idling mixes.",
             ticks_sent, writes_done);
    $display("Checked %0d results, %0d of them on scanning ticks; %0d mismatches.",
             results_checked, scan_results, fail_count);
    if (fail_count == 0)
      $display("tb_timed_moisture_pump_control passed");
    else
      $display("tb_timed_moisture_pump_control failed");
    $finish;
  end

  // A random register data word for the threshold.
  function automatic logic [tmpc_pkg::CFG_DATA_W-1:0] CFG_DATA_W_rand();
    return tmpc_pkg::CFG_DATA_W'($urandom_range(SAMPLE_MAX));
  endfunction

endmodule
